/* sv/sbt_pkg.sv */
// shared types and constants for the sorted bag table
// no dependencies; imported by every module of the block
package sbt_pkg;

	localparam int VAL_W         = 32;
	localparam int POS_W         = 5;
	localparam int DEPTH_DEFAULT = 16;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_REMOVE   = 2'd1,
		CMD_CONTAINS = 2'd2,
		CMD_SEARCH   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic             status;
		logic [POS_W-1:0] entry_count;
	} rsp_t;

	// update control broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

/* sv/sbt_cell.sv */
// one storage cell of the sorted chain: holds an entry and its compare flags
// depends on sbt_pkg
module sbt_cell import sbt_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic                    clk,
	input  logic                    cmp_en,
	input  cell_ctl_t               ctl,
	input  logic signed [VAL_W-1:0] key,
	input  logic [CW-1:0]           count,
	input  logic signed [VAL_W-1:0] left_entry,
	input  logic                    left_lt,
	input  logic signed [VAL_W-1:0] right_entry,
	output logic signed [VAL_W-1:0] entry,
	output logic                    lt,
	output logic                    eq
);

	logic signed [VAL_W-1:0] entry_q;
	logic                    lt_q;
	logic                    eq_q;
	logic                    occ;

	assign occ = count > CW'(IDX);

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			lt_q <= occ && (entry_q < key);
			eq_q <= occ && (entry_q == key);
		end
	end

	// cells at and above the lower bound move up on insert, down on remove
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt_q) begin
			entry_q <= left_lt ? key : left_entry;
		end else if (ctl.rem && !lt_q) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

/* sv/sbt_pos_enc.sv */
// turns the thermometer of less-than flags into the lower-bound index and hit
// depends on sbt_pkg
module sbt_pos_enc import sbt_pkg::*; #(
	parameter int N  = DEPTH_DEFAULT,
	parameter int CW = 5
) (
	input  logic [N-1:0]  lt,
	input  logic [N-1:0]  eq,
	output logic [CW-1:0] pos,
	output logic          hit
);

	logic [N:0] bnd;

	// boundary sits where the cell below is less and this one is not
	assign bnd = {lt, 1'b1} & ~{1'b0, lt};
	assign hit = |(bnd[N-1:0] & eq);

	always_comb begin
		pos = '0;
		for (int i = 0; i <= N; i++) begin
			if (bnd[i]) begin
				pos = pos | CW'(i);
			end
		end
	end

endmodule

/* sv/sorted_bag_table_unit.sv */
// Sorted bag table: keeps up to TABLE_DEPTH signed 32-bit values in ascending
// order in a chain of cells and serves insert, remove, contains and
// lower-bound requests. Each request passes through the accepting beat, a
// compare cycle in which every cell tests its entry against the key at once,
// and an update step in which the position encoder picks the lower bound and,
// on insert or remove, cells at and above it take a neighbour's entry; the
// update step waits while the result side stalls. A new request is taken in
// the cycle after the previous result is loaded, never while one is in flight.
// Inserts into a full table are dropped and reported with status set.
// depends on sbt_pkg, sbt_cell, sbt_pos_enc
module sorted_bag_table_unit import sbt_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t                  state_q;
	state_t                  state_d;
	cmd_t                    cmd_q;
	logic signed [VAL_W-1:0] key_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           count_d;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    req_fire;
	logic                    cmp_en;
	logic                    can_out;
	logic                    upd_fire;
	logic                    full;
	cell_ctl_t               ctl;

	logic signed [VAL_W-1:0] entry_w [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  lt_w;
	logic [TABLE_DEPTH-1:0]  eq_w;
	logic [CW-1:0]           pos;
	logic                    hit;

	assign req_fire = req_valid && !req_stall;
	assign can_out  = !rsp_valid_q || !rsp_stall;
	assign full     = count_q == CW'(TABLE_DEPTH);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_CMP;
			end
			ST_CMP: state_d = ST_UPD;
			ST_UPD: begin
				if (can_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		cmp_en    = 1'b0;
		upd_fire  = 1'b0;
		unique case (state_q)
			ST_IDLE: req_stall = 1'b0;
			ST_CMP:  cmp_en    = 1'b1;
			ST_UPD:  upd_fire  = can_out;
			default: req_stall = 1'b1;
		endcase
	end

	always_comb begin
		ctl.ins = upd_fire && (cmd_q == CMD_INSERT) && !full;
		ctl.rem = upd_fire && (cmd_q == CMD_REMOVE) && hit;
		count_d = count_q;
		if (ctl.ins) begin
			count_d = count_q + CW'(1);
		end else if (ctl.rem) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (upd_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q <= req.cmd;
			key_q <= req.value;
		end
		if (upd_fire) begin
			rsp_q.found       <= hit;
			rsp_q.position    <= POS_W'(pos);
			rsp_q.status      <= (cmd_q == CMD_INSERT) && full;
			rsp_q.entry_count <= POS_W'(count_d);
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_entry;
		logic                    left_lt;
		logic signed [VAL_W-1:0] right_entry;

		if (i == 0) begin : g_first
			assign left_entry = key_q;
			assign left_lt    = 1'b1;
		end else begin : g_mid
			assign left_entry = entry_w[i-1];
			assign left_lt    = lt_w[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign right_entry = entry_w[i];
		end else begin : g_low
			assign right_entry = entry_w[i+1];
		end

		sbt_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.cmp_en      (cmp_en),
			.ctl         (ctl),
			.key         (key_q),
			.count       (count_q),
			.left_entry  (left_entry),
			.left_lt     (left_lt),
			.right_entry (right_entry),
			.entry       (entry_w[i]),
			.lt          (lt_w[i]),
			.eq          (eq_w[i])
		);
	end

	sbt_pos_enc #(
		.N  (TABLE_DEPTH),
		.CW (CW)
	) u_pos_enc (
		.lt  (lt_w),
		.eq  (eq_w),
		.pos (pos),
		.hit (hit)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_lt_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> ((lt_w & ~{lt_w[TABLE_DEPTH-2:0], 1'b1}) == '0))
		else $error("less-than flags not a thermometer");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status) |-> (rsp_q.entry_count == POS_W'(TABLE_DEPTH)))
		else $error("insert rejected with room left");

	a_upd_loads: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> (rsp_valid_q && state_q == ST_IDLE))
		else $error("update did not load a result");

endmodule

/* tb/sorted_bag_table_unit_test.sv */
// self-checking bench for the sorted bag table: drives request beats, predicts each
// response from its own copy of the bag and compares them in order
// depends on sbt_pkg and sorted_bag_table_unit
`timescale 1ns / 1ps

module sorted_bag_table_unit_test import sbt_pkg::*;;

	localparam int DEPTH       = DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 200000;
	localparam int INT_MIN     = 32'sh8000_0000;
	localparam int INT_MAX     = 32'sh7fff_ffff;

	typedef struct {
		req_t beat;
		bit   drain;
	} pending_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_beat = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_beat;

	pending_req_t req_backlog[$];
	rsp_t         rsp_due[$];
	int           seen_vals[$];
	int           bag_vals[DEPTH];
	int           bag_count = 0;
	int           idle_pct = 0;
	int           stall_pct = 0;
	int           fail_count = 0;
	int           cycle_count = 0;
	rsp_t         want_rsp;

	sorted_bag_table_unit #(.TABLE_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_beat)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// applies one request to the bag copy and returns the response it should give
	function automatic rsp_t bag_apply(req_t r);
		int   key;
		int   lb;
		int   i;
		bit   hit;
		rsp_t o;
		key = r.value;
		lb = 0;
		while (lb < bag_count && bag_vals[lb] < key)
			lb++;
		hit = (lb < bag_count) && (bag_vals[lb] == key);
		o.status = 1'b0;
		case (r.cmd)
			CMD_INSERT: begin
				if (bag_count >= DEPTH) begin
					o.status = 1'b1;
				end else begin
					for (i = bag_count; i > lb; i--)
						bag_vals[i] = bag_vals[i-1];
					bag_vals[lb] = key;
					bag_count++;
				end
			end
			CMD_REMOVE: begin
				if (hit) begin
					for (i = lb; i + 1 < bag_count; i++)
						bag_vals[i] = bag_vals[i+1];
					bag_count--;
				end
			end
			default: ;
		endcase
		o.found       = hit;
		o.position    = lb[POS_W-1:0];
		o.entry_count = bag_count[POS_W-1:0];
		return o;
	endfunction

	task automatic push_req(cmd_t c, int v, bit drain);
		pending_req_t p;
		p.beat.cmd   = c;
		p.beat.value = v;
		p.drain      = drain;
		req_backlog.push_back(p);
		seen_vals.push_back(v);
		if (seen_vals.size() > 24)
			void'(seen_vals.pop_front());
	endtask

	// often values already used so that removes and contains hit, plus duplicates
	function automatic int pick_value();
		int kind;
		kind = $urandom_range(9);
		if (kind < 4 && seen_vals.size() != 0)
			return seen_vals[$urandom_range(seen_vals.size() - 1)];
		if (kind < 6)
			return int'($urandom_range(8)) - 4;
		if (kind == 6)
			case ($urandom_range(3))
				0: return INT_MIN;
				1: return INT_MAX;
				2: return 0;
				default: return -1;
			endcase
		return $urandom;
	endfunction

	task automatic queue_random(int n, int ins_pct, bit drain_first);
		int   k;
		int   roll;
		cmd_t c;
		for (k = 0; k < n; k++) begin
			roll = $urandom_range(99);
			if (roll < ins_pct)
				c = CMD_INSERT;
			else if (roll < ins_pct + (100 - ins_pct) / 2)
				c = CMD_REMOVE;
			else
				c = $urandom_range(1) ? CMD_CONTAINS : CMD_SEARCH;
			push_req(c, pick_value(), drain_first && k == 0);
		end
	endtask

	// request driver: a new beat is only offered once the previous one has gone
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_beat  <= '0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid)
				rsp_due.push_back(bag_apply(req_beat));
			if (req_backlog.size() != 0 && !(req_backlog[0].drain && rsp_due.size() != 0)
					&& $urandom_range(99) >= idle_pct) begin
				req_valid <= 1'b1;
				req_beat  <= req_backlog[0].beat;
				void'(req_backlog.pop_front());
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				$error("response beat with nothing outstanding: %p", rsp_beat);
				fail_count++;
			end else begin
				want_rsp = rsp_due.pop_front();
				if (rsp_beat.found !== want_rsp.found) begin
					$error("found: expected %0d, got %0d", want_rsp.found, rsp_beat.found);
					fail_count++;
				end
				if (rsp_beat.position !== want_rsp.position) begin
					$error("position: expected %0d, got %0d",
						want_rsp.position, rsp_beat.position);
					fail_count++;
				end
				if (rsp_beat.status !== want_rsp.status) begin
					$error("status: expected %0d, got %0d", want_rsp.status, rsp_beat.status);
					fail_count++;
				end
				if (rsp_beat.entry_count !== want_rsp.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						want_rsp.entry_count, rsp_beat.entry_count);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sorted_bag_table_unit: mismatch");
			$finish;
		end
	end

	initial begin
		int k;
		int ph;
		int blk;

		// empty table first
		push_req(CMD_SEARCH, 5, 1'b0);
		push_req(CMD_CONTAINS, 0, 1'b0);
		push_req(CMD_REMOVE, 3, 1'b0);
		push_req(CMD_INSERT, INT_MIN, 1'b0);
		push_req(CMD_INSERT, INT_MAX, 1'b0);
		push_req(CMD_INSERT, 0, 1'b0);
		// duplicate goes in front of its equal
		push_req(CMD_INSERT, 0, 1'b0);
		push_req(CMD_INSERT, -1, 1'b0);
		push_req(CMD_INSERT, 1, 1'b0);
		push_req(CMD_CONTAINS, INT_MAX, 1'b0);
		push_req(CMD_SEARCH, 2, 1'b0);
		push_req(CMD_REMOVE, 0, 1'b0);
		push_req(CMD_REMOVE, 7, 1'b0);
		// fill up, then an insert that must bounce
		for (k = 0; k < 11; k++)
			push_req(CMD_INSERT, (k * 32'h1357_9bdf) ^ 32'h5555_aaaa, 1'b0);
		push_req(CMD_INSERT, 42, 1'b0);
		push_req(CMD_CONTAINS, 42, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0)
			@(posedge clk);

		// phases: no idling, sender idle, receiver stalling, both
		for (ph = 0; ph < 4; ph++) begin
			@(negedge clk);
			idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 12 : 0;
			stall_pct = (ph == 2) ? 59 : (ph == 3) ? 12 : 0;
			// alternate filling and draining stretches so full and empty both recur
			for (blk = 0; blk < 4; blk++)
				queue_random(25, (blk % 2) ? 30 : 65, blk == 0);
			while (req_backlog.size() != 0)
				@(posedge clk);
		end

		while (req_backlog.size() != 0 || req_valid)
			@(posedge clk);
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("sorted_bag_table_unit: match");
		else
			$display("sorted_bag_table_unit: mismatch");
		$finish;
	end

endmodule
